@@ rtl/sgpw_pkg.sv @@
// Shared types and constants for the seven-segment glyph pixel writer.
// Holds request, dot and configuration structs plus the digit segment table.
// No dependencies.
`default_nettype none

package sgpw_pkg;

    localparam int SEG_W  = 4;   // segment length register width
    localparam int RADD_W = 5;   // row offset within a glyph, up to twice a segment
    localparam int ABS_W  = 14;  // origin + panning offset + glyph offset

    localparam logic [6:0] GLYPH_DASH  = 7'd100;
    localparam logic [6:0] GLYPH_COLON = 7'd101;

    // segment bits: top, middle, bottom, upper-left, upper-right, lower-left, lower-right
    localparam logic [6:0] SEG_MID = 7'b000_0010;

    localparam logic [6:0] DIGIT_SEGS [10] = '{
        7'd125, 7'd40, 7'd55, 7'd87, 7'd90, 7'd79, 7'd111, 7'd89, 7'd127, 7'd95
    };

    typedef enum logic [2:0] {
        CFG_SEG_WIDTH   = 3'd0,
        CFG_SEG_HEIGHT  = 3'd1,
        CFG_X_OFFSET    = 3'd2,
        CFG_Y_OFFSET    = 3'd3,
        CFG_BYTES_PIXEL = 3'd4,
        CFG_LINE_STRIDE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [6:0]  glyph_code;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [7:0]  in_alpha;
    } req_t;

    typedef struct packed {
        logic [31:0] pixel_address;
        logic [31:0] pixel_word;
        logic        last_dot;
    } dot_t;

    typedef struct packed {
        logic [11:0] x_offset;
        logic [11:0] y_offset;
        logic [2:0]  bytes_per_pixel;
        logic [15:0] line_stride;
    } addr_cfg_t;

    // one dot position relative to the glyph origin
    typedef struct packed {
        logic [SEG_W-1:0]  col_add;
        logic [RADD_W-1:0] row_add;
        logic              last;
    } dot_cmd_t;

    function automatic logic [6:0] seg_mask(input logic [6:0] code);
        logic [6:0] r;
        r = '0;
        case (code) inside
            [7'd0:7'd9]: r = DIGIT_SEGS[code[3:0]];
            GLYPH_DASH:  r = SEG_MID;
            default:     r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sgpw_seq.sv @@
// Dot sequencer: walks the lit segments of one glyph, one dot per advance.
// Depends on sgpw_pkg for the segment table and the dot command struct.
`default_nettype none

module sgpw_seq (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [6:0]                code,
    input  wire logic [sgpw_pkg::SEG_W-1:0] seg_w,
    input  wire logic [sgpw_pkg::SEG_W-1:0] seg_h,
    input  wire logic                      adv,
    output logic                           busy,
    output sgpw_pkg::dot_cmd_t             cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_HORZ  = 4'b0010,
        ST_VERT  = 4'b0100,
        ST_COLON = 4'b1000
    } seq_state_t;

    localparam logic [3:0] COLON_MASK = 4'b0011;

    seq_state_t                 state_reg, state_next;
    logic [sgpw_pkg::SEG_W-1:0] i_reg, i_next;
    logic [1:0]                 sub_reg, sub_next;
    logic [2:0]                 hmask_reg, hmask_next;
    logic [3:0]                 vmask_reg, vmask_next;

    logic [3:0]                 m_cur;
    logic [sgpw_pkg::SEG_W-1:0] lim;
    logic [sgpw_pkg::SEG_W-1:0] i_inc;
    logic [2:0]                 nxt;
    logic [6:0]                 smask;
    logic                       more_i;
    logic                       to_vert;

    // lowest set bit of m at or above index from; msb flags a hit
    function automatic logic [2:0] pick_bit(input logic [3:0] m, input logic [2:0] from);
        logic [2:0] r;
        r = '0;
        for (int k = 3; k >= 0; k--)
        begin
            if (m[k] && (3'(k) >= from))
            begin
                r = {1'b1, 2'(k)};
            end
        end
        return r;
    endfunction

    // index of the lowest set bit of m
    function automatic logic [1:0] first_bit(input logic [3:0] m);
        logic [1:0] r;
        r = '0;
        for (int k = 3; k >= 0; k--)
        begin
            if (m[k])
            begin
                r = 2'(k);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        case (state_reg)
            ST_HORZ:  m_cur = {1'b0, hmask_reg};
            ST_VERT:  m_cur = vmask_reg;
            ST_COLON: m_cur = COLON_MASK;
            default:  m_cur = '0;
        endcase
        case (state_reg)
            ST_HORZ:  lim = seg_w;
            ST_VERT:  lim = seg_h;
            ST_COLON: lim = seg_h >> 1;
            default:  lim = '0;
        endcase
    end

    assign i_inc   = i_reg + 1'b1;
    assign nxt     = pick_bit(m_cur, {1'b0, sub_reg} + 3'd1);
    assign more_i  = (i_inc < lim);
    assign to_vert = (state_reg == ST_HORZ) && (vmask_reg != '0) && (seg_h != '0);
    assign smask   = sgpw_pkg::seg_mask(code);
    assign busy    = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        sub_next   = sub_reg;
        hmask_next = hmask_reg;
        vmask_next = vmask_reg;
        if (state_reg == ST_IDLE)
        begin
            if (start)
            begin
                hmask_next = smask[2:0];
                vmask_next = smask[6:3];
                if (code == sgpw_pkg::GLYPH_COLON)
                begin
                    if ((seg_h >> 2) < (seg_h >> 1))
                    begin
                        state_next = ST_COLON;
                        i_next     = seg_h >> 2;
                        sub_next   = '0;
                    end
                end
                else if ((smask[2:0] != '0) && (seg_w != '0))
                begin
                    state_next = ST_HORZ;
                    i_next     = '0;
                    sub_next   = first_bit({1'b0, smask[2:0]});
                end
                else if ((smask[6:3] != '0) && (seg_h != '0))
                begin
                    state_next = ST_VERT;
                    i_next     = '0;
                    sub_next   = first_bit(smask[6:3]);
                end
            end
        end
        else if (adv)
        begin
            if (nxt[2])
            begin
                sub_next = nxt[1:0];
            end
            else if (more_i)
            begin
                i_next   = i_inc;
                sub_next = first_bit(m_cur);
            end
            else if (to_vert)
            begin
                state_next = ST_VERT;
                i_next     = '0;
                sub_next   = first_bit(vmask_reg);
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    // dot position for the current step
    always_comb
    begin
        cmd.last = !nxt[2] && !more_i && !to_vert;
        case (state_reg)
            ST_HORZ:
            begin
                cmd.col_add = i_reg;
                case (sub_reg)
                    2'd0:    cmd.row_add = '0;
                    2'd1:    cmd.row_add = {1'b0, seg_h};
                    default: cmd.row_add = {seg_h, 1'b0};
                endcase
            end
            ST_VERT:
            begin
                cmd.col_add = sub_reg[0] ? seg_w : '0;
                cmd.row_add = sub_reg[1] ? ({1'b0, seg_h} + {1'b0, i_reg}) : {1'b0, i_reg};
            end
            ST_COLON:
            begin
                cmd.col_add = seg_w >> 1;
                cmd.row_add = sub_reg[0] ? ({1'b0, seg_h} + {1'b0, i_reg}) : {1'b0, i_reg};
            end
            default:
            begin
                cmd.col_add = '0;
                cmd.row_add = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            sub_reg   <= '0;
            hmask_reg <= '0;
            vmask_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            sub_reg   <= sub_next;
            hmask_reg <= hmask_next;
            vmask_reg <= vmask_next;
        end
    end

`ifndef SYNTHESIS
    a_last_ends_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && adv && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("sequencer still busy after last dot");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !adv) |=> ($stable(i_reg) && $stable(sub_reg) && $stable(state_reg)))
        else $error("sequencer moved without an advance");

    a_horz_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HORZ) |-> ((sub_reg != 2'd3) && hmask_reg[sub_reg]))
        else $error("horizontal step on an unlit segment");

    a_vert_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VERT) |-> vmask_reg[sub_reg])
        else $error("vertical step on an unlit segment");
`endif

endmodule

`default_nettype wire

@@ rtl/sgpw_addr.sv @@
// Shared address unit: turns a dot position into a framebuffer byte address
// with two multiplies and an add, and holds the finished dot in the output register.
// Depends on sgpw_pkg for the dot, command and configuration structs.
`default_nettype none

module sgpw_addr (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire sgpw_pkg::dot_cmd_t  cmd,
    input  wire logic [11:0]         origin_x,
    input  wire logic [11:0]         origin_y,
    input  wire logic [31:0]         word,
    input  wire sgpw_pkg::addr_cfg_t cfg,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output sgpw_pkg::dot_t           out_dot
);

    logic [sgpw_pkg::ABS_W-1:0] col_abs;
    logic [sgpw_pkg::ABS_W-1:0] row_abs;
    logic [31:0]                col_term;
    logic [31:0]                row_term;
    logic                       valid_reg;
    sgpw_pkg::dot_t             dot_reg;

    assign col_abs  = sgpw_pkg::ABS_W'(origin_x) + sgpw_pkg::ABS_W'(cmd.col_add)
                    + sgpw_pkg::ABS_W'(cfg.x_offset);
    assign row_abs  = sgpw_pkg::ABS_W'(origin_y) + sgpw_pkg::ABS_W'(cmd.row_add)
                    + sgpw_pkg::ABS_W'(cfg.y_offset);
    assign col_term = 32'(col_abs) * 32'(cfg.bytes_per_pixel);
    assign row_term = 32'(row_abs) * 32'(cfg.line_stride);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dot_reg.pixel_address <= col_term + row_term;
            dot_reg.pixel_word    <= word;
            dot_reg.last_dot      <= cmd.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_dot   = dot_reg;

endmodule

`default_nettype wire

@@ rtl/segment_glyph_pixel_writer_top.sv @@
// Top level of the seven-segment glyph pixel writer: configuration registers,
// request register, dot sequencer and address unit.
// Depends on sgpw_pkg, sgpw_seq and sgpw_addr.
`default_nettype none

// A glyph request (origin, code, RGBA color) becomes one framebuffer write per
// lit dot, red in the lowest byte of pixel_word. The sequencer walks the
// segments and feeds the single address multiply-add unit, which fills the
// output register with one dot per clock while dot_stall is low. A glyph gives
// one write per lit dot, up to 3 * segment width + 4 * segment height dots
// (56 at the default of 8); codes that draw nothing are accepted and give none.
// req_stall stays high while the dots of a glyph are being generated; the next
// request is taken once the last dot sits in the output register. Segment
// lengths above MAX_SEGMENT_LEN are treated as MAX_SEGMENT_LEN.
module segment_glyph_pixel_writer_top #(
    parameter int MAX_SEGMENT_LEN = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire sgpw_pkg::req_t req_data,
    output logic                dot_valid,
    input  wire logic           dot_stall,
    output sgpw_pkg::dot_t      dot_data,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [15:0]    cfg_data
);

    logic [sgpw_pkg::SEG_W-1:0] seg_width_reg;
    logic [sgpw_pkg::SEG_W-1:0] seg_height_reg;
    sgpw_pkg::addr_cfg_t        acfg_reg;
    sgpw_pkg::req_t             req_reg;

    logic [sgpw_pkg::SEG_W-1:0] seg_w;
    logic [sgpw_pkg::SEG_W-1:0] seg_h;
    logic                       start;
    logic                       busy;
    logic                       adv;
    sgpw_pkg::dot_cmd_t         cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_width_reg            <= 4'd8;
            seg_height_reg           <= 4'd8;
            acfg_reg.x_offset        <= '0;
            acfg_reg.y_offset        <= '0;
            acfg_reg.bytes_per_pixel <= 3'd4;
            acfg_reg.line_stride     <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (sgpw_pkg::cfg_index_t'(cfg_index))
                sgpw_pkg::CFG_SEG_WIDTH:   seg_width_reg            <= cfg_data[3:0];
                sgpw_pkg::CFG_SEG_HEIGHT:  seg_height_reg           <= cfg_data[3:0];
                sgpw_pkg::CFG_X_OFFSET:    acfg_reg.x_offset        <= cfg_data[11:0];
                sgpw_pkg::CFG_Y_OFFSET:    acfg_reg.y_offset        <= cfg_data[11:0];
                sgpw_pkg::CFG_BYTES_PIXEL: acfg_reg.bytes_per_pixel <= cfg_data[2:0];
                sgpw_pkg::CFG_LINE_STRIDE: acfg_reg.line_stride     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // saturate segment lengths
    assign seg_w = (seg_width_reg > sgpw_pkg::SEG_W'(MAX_SEGMENT_LEN))
                 ? sgpw_pkg::SEG_W'(MAX_SEGMENT_LEN) : seg_width_reg;
    assign seg_h = (seg_height_reg > sgpw_pkg::SEG_W'(MAX_SEGMENT_LEN))
                 ? sgpw_pkg::SEG_W'(MAX_SEGMENT_LEN) : seg_height_reg;

    assign req_stall = busy;
    assign start     = req_valid && !busy;
    assign adv       = busy && (!dot_valid || !dot_stall);

    // hold the request for the whole glyph
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= req_data;
        end
    end

    sgpw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .code  (req_data.glyph_code),
        .seg_w (seg_w),
        .seg_h (seg_h),
        .adv   (adv),
        .busy  (busy),
        .cmd   (cmd)
    );

    sgpw_addr u_addr (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cmd       (cmd),
        .origin_x  (req_reg.origin_x),
        .origin_y  (req_reg.origin_y),
        .word      ({req_reg.in_alpha, req_reg.in_blue, req_reg.in_green, req_reg.in_red}),
        .cfg       (acfg_reg),
        .out_stall (dot_stall),
        .out_valid (dot_valid),
        .out_dot   (dot_data)
    );

endmodule

`default_nettype wire
